### design/nfec_pkg.sv
`timescale 1ns / 1ps
// Shared types, type codes and byte helpers for the numeric format converter.
// No dependencies.
package nfec_pkg;

  typedef enum logic [2:0] {
    SI8  = 3'd0,
    SI16 = 3'd1,
    SI32 = 3'd2,
    UI8  = 3'd3,
    UI16 = 3'd4,
    UI32 = 3'd5,
    F32  = 3'd6,
    F64  = 3'd7
  } num_type_t;

  // register indexes on the config port
  localparam logic [1:0] REG_IN_TYPE  = 2'd0;
  localparam logic [1:0] REG_IN_BE    = 2'd1;
  localparam logic [1:0] REG_OUT_TYPE = 2'd2;
  localparam logic [1:0] REG_OUT_BE   = 2'd3;

  typedef struct packed {
    logic [63:0] raw_word;
    logic        last_in;
  } src_item_t;

  typedef struct packed {
    logic [63:0] converted_word;
    logic        clipped;
    logic        last_out;
  } dst_item_t;

  // element size in bytes
  function automatic logic [3:0] type_bytes(input num_type_t t);
    logic [3:0] n;
    case (t)
      SI8, UI8:         n = 4'd1;
      SI16, UI16:       n = 4'd2;
      SI32, UI32, F32:  n = 4'd4;
      default:          n = 4'd8;
    endcase
    return n;
  endfunction

  // keep the low n bytes, zero the rest
  function automatic logic [63:0] lane_mask(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd1:    r = {56'd0, v[7:0]};
      4'd2:    r = {48'd0, v[15:0]};
      4'd4:    r = {32'd0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // reverse the low n bytes
  function automatic logic [63:0] swap_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    case (n)
      4'd1:    r = {56'd0, v[7:0]};
      4'd2:    r = {48'd0, v[7:0], v[15:8]};
      4'd4:    r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
      default: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                    v[39:32], v[47:40], v[55:48], v[63:56]};
    endcase
    return r;
  endfunction

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] c;
    logic       found;
    c = 5'd31;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && v[i]) begin
        c = 5'(31 - i);
        found = 1'b1;
      end
    end
    return c;
  endfunction

endpackage

### design/numeric_format_and_endian_converter_core.sv
`timescale 1ns / 1ps
// Numeric format and byte-order converter, four-stage pipeline.
// Depends on nfec_pkg.
//
// Converts one element per transaction between int8/16/32, uint8/16/32, float32
// and float64, with independent input and output byte order, by C conversion
// rules (integer wrap, round-to-nearest-even into floats, truncation into
// integers, saturation plus the clipped flag for out-of-range or NaN float to
// integer). A transaction can enter every clock while dst is not stalled. The
// result passes through four registered stages: byte order, widening to a
// float64 form (normalize count), shift/round prep, round/saturate plus output
// byte order. Bubbles collapse and a stall on dst holds everything in place.
// Write the four config registers (byte addresses 0, 4, 8, 12) only while idle.
module numeric_format_and_endian_converter_core import nfec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_stall,
  input  src_item_t   src_data,
  output logic        dst_valid,
  input  logic        dst_stall,
  output dst_item_t   dst_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration ----------------
  num_type_t in_type, out_type;
  logic      in_big_endian, out_big_endian;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_type        <= SI8;
      out_type       <= SI8;
      in_big_endian  <= 1'b0;
      out_big_endian <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_IN_TYPE:  in_type        <= num_type_t'(pwdata[2:0]);
        REG_IN_BE:    in_big_endian  <= pwdata[0];
        REG_OUT_TYPE: out_type       <= num_type_t'(pwdata[2:0]);
        REG_OUT_BE:   out_big_endian <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IN_TYPE:  prdata = {29'd0, in_type};
      REG_IN_BE:    prdata = {31'd0, in_big_endian};
      REG_OUT_TYPE: prdata = {29'd0, out_type};
      REG_OUT_BE:   prdata = {31'd0, out_big_endian};
      default:      prdata = 32'd0;
    endcase
  end

  logic [3:0] nin, nout;
  logic       in_float, out_float;
  assign nin       = type_bytes(in_type);
  assign nout      = type_bytes(out_type);
  assign in_float  = (in_type == F32) || (in_type == F64);
  assign out_float = (out_type == F32) || (out_type == F64);

  // ---------------- handshake: per-stage ready, bubbles collapse ----------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, out_rdy;
  assign out_rdy   = !dst_valid || !dst_stall;
  assign rdy3      = !v3 || out_rdy;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign src_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; dst_valid <= 1'b0;
    end else begin
      if (rdy1)    v1 <= src_valid;
      if (rdy2)    v2 <= v1;
      if (rdy3)    v3 <= v2;
      if (out_rdy) dst_valid <= v3;
    end
  end

  // ---------------- stage 1: mask and input byte order ----------------
  logic [63:0] s1_v;
  logic        s1_last;
  logic [63:0] s1_v_next;

  always_comb begin
    s1_v_next = lane_mask(src_data.raw_word, nin);
    if (in_big_endian) s1_v_next = swap_bytes(s1_v_next, nin);
  end

  always_ff @(posedge clk) begin
    if (src_valid && rdy1) begin
      s1_v    <= s1_v_next;
      s1_last <= src_data.last_in;
    end
  end

  // ---------------- stage 2: integer value and float64 form ----------------
  logic [63:0]        s2_v, s2_fb;
  logic signed [32:0] s2_ival;
  logic               s2_last;
  logic [63:0]        fb_next;
  logic signed [32:0] ival_next;

  always_comb begin
    logic [31:0] mag, sub_man;
    logic [4:0]  lz, slz;
    logic        neg;
    logic [31:0] fr;
    logic [22:0] sman;
    logic [10:0] sexp;
    case (in_type)
      SI8:     ival_next = 33'(signed'(s1_v[7:0]));
      SI16:    ival_next = 33'(signed'(s1_v[15:0]));
      SI32:    ival_next = 33'(signed'(s1_v[31:0]));
      default: ival_next = signed'({1'b0, s1_v[31:0]});
    endcase
    neg = ival_next[32];
    mag = neg ? 32'(-ival_next) : ival_next[31:0];
    lz  = lzc32(mag);
    fr  = mag << lz;
    // float32 subnormal normalization
    sub_man = {9'd0, s1_v[22:0]};
    slz     = lzc32(sub_man);
    sman    = 23'(sub_man << (slz - 5'd8));
    sexp    = 11'd874 + 11'(5'd31 - slz);
    case (in_type)
      F64: fb_next = s1_v;
      F32: begin
        if (s1_v[30:23] == 8'hff) begin
          if (s1_v[22:0] != 23'd0)
            fb_next = {s1_v[31], 11'h7ff, 1'b1, s1_v[21:0], 29'd0};
          else
            fb_next = {s1_v[31], 11'h7ff, 52'd0};
        end else if (s1_v[30:23] == 8'd0) begin
          if (s1_v[22:0] == 23'd0) fb_next = {s1_v[31], 63'd0};
          else                     fb_next = {s1_v[31], sexp, sman, 29'd0};
        end else begin
          fb_next = {s1_v[31], 11'(s1_v[30:23]) + 11'd896, s1_v[22:0], 29'd0};
        end
      end
      default: begin
        if (mag == 32'd0) fb_next = 64'd0;
        else fb_next = {neg, 11'd1023 + 11'(5'd31 - lz), fr[30:0], 21'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_v    <= s1_v;
      s2_fb   <= fb_next;
      s2_ival <= ival_next;
      s2_last <= s1_last;
    end
  end

  // ---------------- stage 3: shift and round prep ----------------
  logic [63:0]        s3_v, s3_fb;
  logic signed [32:0] s3_ival;
  logic               s3_last;
  logic [40:0]        s3_ipart;
  logic               s3_nan, s3_inf, s3_big, s3_sign;
  logic               s3_sp;       // float32 result fixed here
  logic [31:0]        s3_spval;
  logic [23:0]        s3_q;
  logic               s3_rup;
  logic [10:0]        s3_ebias;

  logic [40:0] ipart_next;
  logic        nan_next, inf_next, big_next, sp_next, rup_next;
  logic [31:0] spval_next;
  logic [23:0] q_next;
  logic [10:0] ebias_next;

  always_comb begin
    logic [10:0] ex;
    logic [51:0] man;
    logic [52:0] m;
    logic [5:0]  sh, ish;
    logic        normal;
    logic [63:0] mq, gmask;
    ex  = s2_fb[62:52];
    man = s2_fb[51:0];
    m   = {ex != 11'd0, man};
    nan_next = (ex == 11'h7ff) && (man != 52'd0);
    inf_next = (ex == 11'h7ff) && (man == 52'd0);
    big_next = (ex > 11'd1063);
    ish = 6'(11'd1075 - ex);
    if (ex < 11'd1023 || big_next) ipart_next = 41'd0;
    else ipart_next = 41'(m >> ish);
    // float64 -> float32 rounding prep
    normal = (ex >= 11'd897);
    sh     = normal ? 6'd29 : 6'(11'd926 - ex);
    mq     = 64'(m) >> sh;
    gmask  = (64'd1 << (sh - 6'd1)) - 64'd1;
    q_next = mq[23:0];
    rup_next = ((64'(m) >> (sh - 6'd1)) & 64'd1) != 64'd0 &&
               (((64'(m) & gmask) != 64'd0) || mq[0]);
    ebias_next = normal ? (ex - 11'd897) : 11'd0;
    sp_next    = 1'b1;
    if (nan_next)           spval_next = {s2_fb[63], 8'hff, 1'b1, man[50:29]};
    else if (inf_next)      spval_next = {s2_fb[63], 8'hff, 23'd0};
    else if (ex < 11'd866)  spval_next = {s2_fb[63], 31'd0};
    else begin
      spval_next = {s2_fb[63], 31'd0};
      sp_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      s3_v     <= s2_v;
      s3_fb    <= s2_fb;
      s3_ival  <= s2_ival;
      s3_last  <= s2_last;
      s3_ipart <= ipart_next;
      s3_nan   <= nan_next;
      s3_inf   <= inf_next;
      s3_big   <= big_next;
      s3_sign  <= s2_fb[63];
      s3_sp    <= sp_next;
      s3_spval <= spval_next;
      s3_q     <= q_next;
      s3_rup   <= rup_next;
      s3_ebias <= ebias_next;
    end
  end

  // ---------------- stage 4: round, saturate, output byte order ----------------
  dst_item_t dst_next;

  always_comb begin
    logic [33:0] sum;
    logic [31:0] f32;
    logic [63:0] res;
    logic        clip, sgn, huge;
    logic [5:0]  w;
    logic [40:0] lim, ulim;
    sum = {s3_ebias, 23'd0} + 34'(s3_q) + 34'(s3_rup);
    if (s3_sp) f32 = s3_spval;
    else if (sum >= 34'h7f800000) f32 = {s3_sign, 8'hff, 23'd0};
    else f32 = {s3_sign, sum[30:0]};

    w    = 6'(8 * nout);
    sgn  = (out_type == SI8) || (out_type == SI16) || (out_type == SI32);
    lim  = 41'd1 << (w - 6'd1);
    ulim = 41'd1 << w;
    huge = s3_inf || s3_big;
    clip = 1'b0;
    if (out_float) begin
      if (in_float && in_type == out_type) res = s3_v;
      else if (out_type == F64)            res = s3_fb;
      else                                  res = {32'd0, f32};
    end else if (!in_float) begin
      res = 64'(s3_ival);
    end else if (s3_nan) begin
      res  = 64'd0;
      clip = 1'b1;
    end else if (sgn) begin
      if (!s3_sign && (huge || s3_ipart >= lim)) begin
        res  = 64'(lim - 41'd1);
        clip = 1'b1;
      end else if (s3_sign && (huge || s3_ipart >= lim + 41'd1)) begin
        res  = 64'd0 - 64'(lim);
        clip = 1'b1;
      end else begin
        res = s3_sign ? 64'd0 - 64'(s3_ipart) : 64'(s3_ipart);
      end
    end else begin
      if (!s3_sign && (huge || s3_ipart >= ulim)) begin
        res  = 64'(ulim - 41'd1);
        clip = 1'b1;
      end else if (s3_sign && (huge || s3_ipart != 41'd0)) begin
        res  = 64'd0;
        clip = 1'b1;
      end else begin
        res = s3_sign ? 64'd0 : 64'(s3_ipart);
      end
    end
    res = lane_mask(res, nout);
    if (out_big_endian) res = swap_bytes(res, nout);
    dst_next.converted_word = res;
    dst_next.clipped        = clip;
    dst_next.last_out       = s3_last;
  end

  always_ff @(posedge clk) begin
    if (v3 && out_rdy) dst_data <= dst_next;
  end

  // ---------------- assertions ----------------
  a_clip_only_float_to_int: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.clipped |-> in_float && !out_float)
    else $error("clipped set on a conversion that is not float to integer");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && (out_type == SI8 || out_type == UI8) |->
      dst_data.converted_word[63:8] == 56'd0)
    else $error("upper lanes not zero for a one-byte output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

endmodule
